### sv/binary_trie_max_xor_multiset_assert.svh
// assertion macros shared by the trie block
`ifndef BINARY_TRIE_MAX_XOR_MULTISET_ASSERT_SVH
`define BINARY_TRIE_MAX_XOR_MULTISET_ASSERT_SVH

// same-cycle implication
`define BTMX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btmx same-cycle check failed");

// next-cycle implication
`define BTMX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btmx next-cycle check failed");

`endif

### sv/btmx_pkg.sv
// shared codes, widths and sequencer states of the max-xor trie
package btmx_pkg;

    localparam int CMD_W   = 2;
    localparam int ST_W    = 2;
    localparam int DATA_W  = 31;
    localparam int TDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_SCAN,
        S_PRIME2,
        S_UPDATE,
        S_LEAF,
        S_DONE
    } t_state;

endpackage

### sv/btmx_node_ram.sv
// node memory: one write port, two registered read ports
module btmx_node_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 41
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

### sv/binary_trie_max_xor_multiset.sv
// max-xor multiset: bitwise trie walked one level per cycle through a node memory
//
//  channel  | dir | tdata          | tuser
//  ---------+-----+----------------+--------------
//  s_axis   | in  | key_value[30:0]| cmd[1:0]
//  m_axis   | out | max_xor[30:0]  | status[1:0]
//
// insert and remove walk the trie twice (check walk, then update walk),
// a query walks it once and an unused command goes straight to done; one
// memory read level per cycle, both children of a node are fetched together.
// one word is worked on at a time; the next word is taken once the result
// sits in the output register, which holds it until m_axis_tready.
// i_rst_n is synchronous; node memory is not cleared, nodes are written when allocated.
`include "binary_trie_max_xor_multiset_assert.svh"

module binary_trie_max_xor_multiset #(
    parameter int KEY_BITS   = 31,
    parameter int POOL_NODES = 4096,
    parameter int COUNT_BITS = 17
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [btmx_pkg::TDATA_W-1:0] s_axis_tdata,  // key_value[30:0]
    input  logic [btmx_pkg::CMD_W-1:0]   s_axis_tuser,  // cmd[1:0]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [btmx_pkg::TDATA_W-1:0] m_axis_tdata,  // max_xor[30:0]
    output logic [btmx_pkg::ST_W-1:0]    m_axis_tuser   // status[1:0]
);

    import btmx_pkg::*;

    localparam int KB    = KEY_BITS;
    localparam int CB    = COUNT_BITS;
    localparam int NW    = $clog2(POOL_NODES);
    localparam int EW    = 2 * NW + CB;
    localparam int LW    = $clog2(KEY_BITS);
    localparam int MW    = $clog2(KEY_BITS + 1);
    localparam int EXT_W = (KEY_BITS > DATA_W) ? KEY_BITS : DATA_W;

    localparam logic [LW-1:0]   LV_LAST  = LW'(KEY_BITS - 1);
    localparam logic [CB-1:0]   CNT_MAX  = {CB{1'b1}};
    localparam logic [NW:0]     FREE_MAX = (NW + 1)'(POOL_NODES);
    localparam logic [NW+1:0]   POOL_CMP = (NW + 2)'(POOL_NODES);

    t_state r_state, n_state;

    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [KB-1:0]    r_key, n_key;
    logic [KB-1:0]    r_sh, n_sh;
    logic [KB-1:0]    r_best, n_best;
    logic [LW-1:0]    r_lv, n_lv;
    logic [NW-1:0]    r_node, n_node;
    logic [NW-1:0]    r_lk0, n_lk0;
    logic [NW-1:0]    r_lk1, n_lk1;
    logic [CB-1:0]    r_cnt, n_cnt;
    logic [NW:0]      r_free, n_free;
    logic [NW-1:0]    r_root0, n_root0;
    logic [NW-1:0]    r_root1, n_root1;
    logic [ST_W-1:0]  r_status, n_status;
    logic [KB-1:0]    r_res, n_res;
    logic             r_out_valid, n_out_valid;
    logic [ST_W-1:0]  r_out_status, n_out_status;
    logic [DATA_W-1:0] r_out_xor, n_out_xor;

    logic [EW-1:0] w_rd_a, w_rd_b;
    logic          w_we;
    logic [NW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;

    logic [EXT_W-1:0] w_in_ext;
    logic [KB-1:0]    w_in_key;
    logic [EXT_W-1:0] w_res_ext;

    logic          w_b, w_first, w_last;
    logic [NW-1:0] w_c, w_o, w_nc;
    logic [EW-1:0] w_ce, w_oe;
    logic          w_c_null, w_alloc, w_take, w_empty, w_fits;
    logic [CB-1:0] w_c_cnt, w_cnt_upd;
    logic [NW-1:0] w_lk0_upd, w_lk1_upd;
    logic [MW-1:0] w_missing;
    logic [KB-1:0] w_best_fin;
    logic          w_out_free, w_in_ok;

    btmx_node_ram #(
        .DEPTH (POOL_NODES),
        .AW    (NW),
        .DW    (EW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (n_lk0),
        .i_raddr_b (n_lk1),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    assign w_in_ext  = EXT_W'(s_axis_tdata[DATA_W-1:0]);
    assign w_in_key  = w_in_ext[KB-1:0];
    assign w_res_ext = EXT_W'(r_res);
    assign w_in_ok   = (s_axis_tuser == CMD_INSERT) || (s_axis_tuser == CMD_REMOVE) ||
                       (s_axis_tuser == CMD_QUERY);

    // r_lk0/r_lk1 are the current node's links, w_rd_a/w_rd_b its children's entries
    assign w_b      = r_sh[KB-1];
    assign w_first  = (r_lv == '0);
    assign w_last   = (r_lv == LV_LAST);
    assign w_c      = w_b ? r_lk1 : r_lk0;
    assign w_ce     = w_b ? w_rd_b : w_rd_a;
    assign w_o      = w_b ? r_lk0 : r_lk1;
    assign w_oe     = w_b ? w_rd_a : w_rd_b;
    assign w_c_null = (w_c == '0);
    assign w_c_cnt  = w_ce[EW-1 -: CB];
    assign w_take   = (w_o != '0) && (w_oe[EW-1 -: CB] != '0);
    assign w_empty  = ((r_lk0 == '0) || (w_rd_a[EW-1 -: CB] == '0)) &&
                      ((r_lk1 == '0) || (w_rd_b[EW-1 -: CB] == '0));
    assign w_missing = MW'(KEY_BITS) - MW'(r_lv);
    assign w_fits    = ({1'b0, r_free} + (NW + 2)'(w_missing)) <= POOL_CMP;
    assign w_best_fin = {r_best[KB-2:0], w_take};

    assign w_alloc   = (r_state == S_UPDATE) && w_c_null;
    assign w_nc      = w_c_null ? r_free[NW-1:0] : w_c;
    assign w_lk0_upd = w_b ? r_lk0 : w_nc;
    assign w_lk1_upd = w_b ? w_nc : r_lk1;
    assign w_cnt_upd = (r_cmd == CMD_INSERT) ? (r_cnt + CB'(1)) :
                       ((r_cnt != '0) ? (r_cnt - CB'(1)) : r_cnt);

    assign w_out_free = !r_out_valid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = w_in_ok ? S_PRIME : S_DONE;
                end
            end
            S_PRIME: n_state = S_SCAN;
            S_SCAN: begin
                case (r_cmd)
                    CMD_INSERT: begin
                        if (w_c_null) begin
                            n_state = w_fits ? S_PRIME2 : S_DONE;
                        end else if (w_c_cnt == CNT_MAX) begin
                            n_state = S_DONE;
                        end else if (w_last) begin
                            n_state = S_PRIME2;
                        end
                    end
                    CMD_REMOVE: begin
                        if (w_c_null) begin
                            n_state = S_DONE;
                        end else if (w_last) begin
                            n_state = (w_c_cnt == '0) ? S_DONE : S_PRIME2;
                        end
                    end
                    default: begin
                        if ((w_first && w_empty) || w_last) begin
                            n_state = S_DONE;
                        end
                    end
                endcase
            end
            S_PRIME2: n_state = S_UPDATE;
            S_UPDATE: begin
                if (w_last) begin
                    n_state = S_LEAF;
                end
            end
            S_LEAF: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_sh         = r_sh;
        n_best       = r_best;
        n_lv         = r_lv;
        n_node       = r_node;
        n_lk0        = r_lk0;
        n_lk1        = r_lk1;
        n_cnt        = r_cnt;
        n_free       = r_free;
        n_root0      = r_root0;
        n_root1      = r_root1;
        n_status     = r_status;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_xor    = r_out_xor;
        w_we         = 1'b0;
        w_waddr      = r_node;
        w_wdata      = {w_cnt_upd, r_lk1, r_lk0};
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd    = s_axis_tuser;
                    n_key    = w_in_key;
                    n_status = ST_OK;
                    n_res    = '0;
                end
            end
            S_PRIME, S_PRIME2: begin
                n_lk0  = r_root0;
                n_lk1  = r_root1;
                n_node = '0;
                n_cnt  = '0;
                n_sh   = r_key;
                n_lv   = '0;
                n_best = '0;
            end
            S_SCAN: begin
                n_sh   = r_sh << 1;
                n_lv   = r_lv + LW'(1);
                n_best = w_best_fin;
                n_node = w_c;
                n_lk0  = w_ce[NW-1:0];
                n_lk1  = w_ce[2*NW-1:NW];
                case (r_cmd)
                    CMD_INSERT: begin
                        if ((w_c_null && !w_fits) || (!w_c_null && w_c_cnt == CNT_MAX)) begin
                            n_status = ST_FULL;
                        end
                    end
                    CMD_REMOVE: begin
                        if (w_c_null || (w_last && w_c_cnt == '0)) begin
                            n_status = ST_ABSENT;
                        end
                    end
                    default: begin
                        if (w_take) begin
                            n_node = w_o;
                            n_lk0  = w_oe[NW-1:0];
                            n_lk1  = w_oe[2*NW-1:NW];
                        end
                        if (w_first && w_empty) begin
                            n_res = r_key;
                        end else if (w_last) begin
                            n_res = (w_best_fin > r_key) ? w_best_fin : r_key;
                        end
                    end
                endcase
            end
            S_UPDATE: begin
                n_sh = r_sh << 1;
                n_lv = r_lv + LW'(1);
                // root lives in registers, deeper nodes are rewritten with new count and link
                if (w_first) begin
                    if (w_c_null) begin
                        if (w_b) begin
                            n_root1 = w_nc;
                        end else begin
                            n_root0 = w_nc;
                        end
                    end
                end else begin
                    w_we    = 1'b1;
                    w_wdata = {w_cnt_upd, w_lk1_upd, w_lk0_upd};
                end
                n_node = w_nc;
                if (w_c_null) begin
                    n_free = r_free + (NW + 1)'(1);
                    n_cnt  = '0;
                    n_lk0  = '0;
                    n_lk1  = '0;
                end else begin
                    n_cnt = w_c_cnt;
                    n_lk0 = w_ce[NW-1:0];
                    n_lk1 = w_ce[2*NW-1:NW];
                end
            end
            S_LEAF: begin
                w_we = 1'b1;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_xor    = (r_cmd == CMD_QUERY) ? w_res_ext[DATA_W-1:0] : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_free      <= (NW + 1)'(1);
            r_root0     <= '0;
            r_root1     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_free      <= n_free;
            r_root0     <= n_root0;
            r_root1     <= n_root1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_sh         <= n_sh;
        r_best       <= n_best;
        r_lv         <= n_lv;
        r_node       <= n_node;
        r_lk0        <= n_lk0;
        r_lk1        <= n_lk1;
        r_cnt        <= n_cnt;
        r_status     <= n_status;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_xor    <= n_out_xor;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_xor);
    assign m_axis_tuser  = r_out_status;

    // the pool pointer never runs past the pool
    `BTMX_ASSERT_SAME(a_free_bound, i_clk, i_rst_n, 1'b1, r_free <= FREE_MAX)
    // every allocation advances the pool pointer by exactly one
    `BTMX_ASSERT_NEXT(a_alloc_step, i_clk, i_rst_n, w_alloc, r_free == $past(r_free) + (NW + 1)'(1))
    // a remove only updates a path that the check walk found complete
    `BTMX_ASSERT_SAME(a_remove_path, i_clk, i_rst_n, (r_state == S_UPDATE) && (r_cmd == CMD_REMOVE), !w_c_null)
    // a finished word waits while the output register is still occupied
    `BTMX_ASSERT_NEXT(a_done_hold, i_clk, i_rst_n, (r_state == S_DONE) && r_out_valid && !m_axis_tready, r_state == S_DONE)

endmodule

### tb/sv/tb_binary_trie_max_xor_multiset.sv
// self-checking testbench for the max-xor trie multiset: directed table, then random traffic
module tb_binary_trie_max_xor_multiset;
    timeunit 1ns;
    timeprecision 1ps;

    import btmx_pkg::*;

    localparam int KEY_W        = 31;
    localparam int POOL         = 4096;
    localparam int CNT_W        = 17;
    localparam int RANDOM_ITEMS = 1050;
    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 80;
    localparam int DIR_N        = 23;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [KEY_W-1:0] max_xor;
    } t_trie_result;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic [KEY_W-1:0] key;
        logic             typed;
        logic [ST_W-1:0]  status;
        logic [KEY_W-1:0] max_xor;
    } t_dir_row;

    // typed rows carry their answer, the rest go through the trie predictor
    localparam t_dir_row [0:DIR_N-1] DIR_ROWS = '{
        '{CMD_QUERY,  31'h00000000, 1'b1, ST_OK,     31'h00000000},
        '{CMD_QUERY,  31'h7FFFFFFF, 1'b1, ST_OK,     31'h7FFFFFFF},
        '{CMD_REMOVE, 31'h00000000, 1'b1, ST_ABSENT, 31'h00000000},
        '{CMD_REMOVE, 31'h7FFFFFFF, 1'b1, ST_ABSENT, 31'h00000000},
        '{CMD_UNUSED, 31'h12345678, 1'b1, ST_OK,     31'h00000000},
        '{CMD_INSERT, 31'h00000000, 1'b1, ST_OK,     31'h00000000},
        '{CMD_INSERT, 31'h7FFFFFFF, 1'b1, ST_OK,     31'h00000000},
        '{CMD_QUERY,  31'h00000000, 1'b1, ST_OK,     31'h7FFFFFFF},
        '{CMD_QUERY,  31'h55555555, 1'b0, ST_OK,     31'h00000000},
        '{CMD_INSERT, 31'h00000000, 1'b0, ST_OK,     31'h00000000},
        '{CMD_REMOVE, 31'h00000000, 1'b0, ST_OK,     31'h00000000},
        '{CMD_REMOVE, 31'h00000000, 1'b0, ST_OK,     31'h00000000},
        '{CMD_REMOVE, 31'h00000000, 1'b0, ST_OK,     31'h00000000},
        '{CMD_REMOVE, 31'h7FFFFFFF, 1'b0, ST_OK,     31'h00000000},
        '{CMD_QUERY,  31'h2AAAAAAA, 1'b0, ST_OK,     31'h00000000},
        '{CMD_REMOVE, 31'h7FFFFFFF, 1'b0, ST_OK,     31'h00000000},
        '{CMD_INSERT, 31'h40000000, 1'b0, ST_OK,     31'h00000000},
        '{CMD_REMOVE, 31'h40000001, 1'b0, ST_OK,     31'h00000000},
        '{CMD_QUERY,  31'h3FFFFFFF, 1'b0, ST_OK,     31'h00000000},
        '{CMD_INSERT, 31'h7FFFFFFF, 1'b0, ST_OK,     31'h00000000},
        '{CMD_QUERY,  31'h7FFFFFFF, 1'b0, ST_OK,     31'h00000000},
        '{CMD_UNUSED, 31'h7FFFFFFF, 1'b0, ST_OK,     31'h00000000},
        '{CMD_QUERY,  31'h00000001, 1'b0, ST_OK,     31'h00000000}
    };

    logic                i_clk;
    logic                i_rst_n  = 1'b0;
    logic                tx_valid = 1'b0;
    logic [TDATA_W-1:0]  tx_data  = '0;
    logic [CMD_W-1:0]    tx_user  = '0;
    logic                rx_ready = 1'b0;
    logic                s_axis_tready;
    logic                m_axis_tvalid;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [ST_W-1:0]     m_axis_tuser;

    // trie copy used for prediction
    logic [11:0]      zero_link [POOL];
    logic [11:0]      one_link  [POOL];
    logic [CNT_W-1:0] pass_cnt  [POOL];
    int unsigned      free_node;

    t_trie_result     pending_answers [$];
    logic [KEY_W-1:0] insert_history [$];
    logic [KEY_W-1:0] key_bases [8];
    int unsigned      mismatch_cnt = 0;
    int unsigned      cycle_cnt    = 0;
    int unsigned      burst_left   = 0;
    int unsigned      rx_left      = 0;
    int unsigned      rx_mode      = 0;

    binary_trie_max_xor_multiset uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (tx_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (tx_data),    // key_value[30:0]
        .s_axis_tuser  (tx_user),    // cmd[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (rx_ready),
        .m_axis_tdata  (m_axis_tdata), // max_xor[30:0]
        .m_axis_tuser  (m_axis_tuser)  // status[1:0]
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_trie_result apply_trie_op(input logic [CMD_W-1:0] op,
                                                   input logic [KEY_W-1:0] key);
        t_trie_result     res;
        int unsigned      node;
        int unsigned      c;
        int unsigned      missing;
        bit               broken;
        bit               saturated;
        bit               found;
        logic             b;
        logic [KEY_W-1:0] best;
        res       = '0;
        node      = 0;
        missing   = 0;
        broken    = 1'b0;
        saturated = 1'b0;
        found     = 1'b1;
        best      = '0;
        case (op)
            CMD_INSERT: begin
                for (int lv = 0; lv < KEY_W; lv++) begin
                    if (broken) begin
                        missing++;
                    end else begin
                        c = key[KEY_W-1-lv] ? one_link[node] : zero_link[node];
                        if (c == 0) begin
                            broken = 1'b1;
                            missing++;
                        end else begin
                            if (pass_cnt[c] == CNT_MAX) saturated = 1'b1;
                            node = c;
                        end
                    end
                end
                if (saturated || free_node + missing > POOL) begin
                    res.status = ST_FULL;
                end else begin
                    node = 0;
                    for (int lv = 0; lv < KEY_W; lv++) begin
                        b = key[KEY_W-1-lv];
                        c = b ? one_link[node] : zero_link[node];
                        if (c == 0) begin
                            c = free_node;
                            free_node++;
                            zero_link[c] = '0;
                            one_link[c]  = '0;
                            pass_cnt[c]  = '0;
                            if (b) one_link[node] = 12'(c);
                            else   zero_link[node] = 12'(c);
                        end
                        pass_cnt[c] = pass_cnt[c] + 1'b1;
                        node = c;
                    end
                end
            end
            CMD_REMOVE: begin
                for (int lv = 0; lv < KEY_W && found; lv++) begin
                    c = key[KEY_W-1-lv] ? one_link[node] : zero_link[node];
                    if (c == 0) found = 1'b0;
                    else        node = c;
                end
                if (found && pass_cnt[node] == 0) found = 1'b0;
                if (!found) begin
                    res.status = ST_ABSENT;
                end else begin
                    node = 0;
                    for (int lv = 0; lv < KEY_W; lv++) begin
                        c = key[KEY_W-1-lv] ? one_link[node] : zero_link[node];
                        if (pass_cnt[c] > 0) pass_cnt[c] = pass_cnt[c] - 1'b1;
                        node = c;
                    end
                end
            end
            CMD_QUERY: begin
                // no stored key under the root: only the permanent zero answers
                if (pass_cnt[zero_link[0]] == 0 && pass_cnt[one_link[0]] == 0) begin
                    res.max_xor = key;
                end else begin
                    for (int lv = 0; lv < KEY_W; lv++) begin
                        b = key[KEY_W-1-lv];
                        c = b ? zero_link[node] : one_link[node];
                        if (c != 0 && pass_cnt[c] > 0) begin
                            best[KEY_W-1-lv] = 1'b1;
                            node = c;
                        end else begin
                            node = b ? one_link[node] : zero_link[node];
                        end
                    end
                    res.max_xor = (best > key) ? best : key;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic typed, input t_trie_result typed_res);
        t_trie_result res;
        if (burst_left == 0) begin
            // gap of zero keeps some bursts back to back
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) begin
                @(negedge i_clk);
                tx_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge i_clk);
        tx_valid <= 1'b1;
        tx_data  <= {1'b0, key};
        tx_user  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        res = apply_trie_op(op, key);
        if (typed) res = typed_res;
        pending_answers = {pending_answers, res};
    endtask

    task automatic drain_answers();
        @(negedge i_clk);
        tx_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] mask;
        mask = (31'd1 << $urandom_range(1, 12)) - 31'd1;
        if ($urandom_range(0, 3) == 0) return 31'($urandom);
        return key_bases[$urandom_range(0, 7)] ^ (31'($urandom) & mask);
    endfunction

    // receiver: ready pattern switches among four modes whenever its countdown runs out
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       rx_ready <= 1'b1;
            1:       rx_ready <= 1'($urandom_range(0, 1));
            2:       rx_ready <= ($urandom_range(0, 3) == 0);
            default: rx_ready <= rx_left[2];
        endcase
    end

    always @(posedge i_clk) begin : check_words
        t_trie_result want;
        if (i_rst_n && m_axis_tvalid && rx_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected word status %0d max_xor %h", $time,
                         m_axis_tuser, m_axis_tdata);
                mismatch_cnt++;
            end else begin
                want = pending_answers.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, m_axis_tuser);
                    mismatch_cnt++;
                end
                if (m_axis_tdata !== {1'b0, want.max_xor}) begin
                    $display("%0t: max_xor expected %h got %h", $time,
                             {1'b0, want.max_xor}, m_axis_tdata);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d words still due", $time, pending_answers.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned      sel;
        logic [CMD_W-1:0] op;
        logic [KEY_W-1:0] key;
        t_trie_result     typed_res;
        for (int i = 0; i < POOL; i++) begin
            zero_link[i] = '0;
            one_link[i]  = '0;
            pass_cnt[i]  = '0;
        end
        free_node = 1;
        foreach (key_bases[i]) key_bases[i] = 31'($urandom);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            typed_res.status  = DIR_ROWS[i].status;
            typed_res.max_xor = DIR_ROWS[i].max_xor;
            send_word(DIR_ROWS[i].op, DIR_ROWS[i].key, DIR_ROWS[i].typed, typed_res);
        end
        drain_answers();

        typed_res = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                op  = CMD_INSERT;
                key = pick_key();
                insert_history = {insert_history, key};
                if (insert_history.size() > 64) void'(insert_history.pop_front());
            end else if (sel < 65) begin
                // mostly keys seen before so removes hit, some misses
                op = CMD_REMOVE;
                if (insert_history.size() != 0 && $urandom_range(0, 4) != 0)
                    key = insert_history[$urandom_range(0, insert_history.size() - 1)];
                else
                    key = pick_key();
            end else if (sel < 97) begin
                op  = CMD_QUERY;
                key = $urandom_range(0, 1) ? 31'($urandom) : pick_key();
            end else begin
                op  = CMD_UNUSED;
                key = 31'($urandom);
            end
            send_word(op, key, 1'b0, typed_res);
            if ($urandom_range(0, 149) == 0) drain_answers();
        end

        drain_answers();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
